// ===== design/tro_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace replay oracle package
// Shared types, codes and defaults for the trace replay branch oracle.
// ----------------------------------------------------------------------------
package tro_pkg;

    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned PC_W        = 64;
    localparam int unsigned UPC_W       = 16;
    localparam int unsigned SEQ_W       = 64;

    typedef enum logic [2:0] {
        OP_LOAD    = 3'd0,
        OP_END     = 3'd1,
        OP_PREDICT = 3'd2,
        OP_SQUASH  = 3'd3,
        OP_COMMIT  = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_REFILL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EVAL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [PC_W-1:0]  branch_pc;
        logic [UPC_W-1:0] branch_upc;
        logic [PC_W-1:0]  target_pc;
        logic [UPC_W-1:0] target_upc;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic capture;
        logic exec;
        logic eval;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    used_zero;
        logic    unused_zero;
        logic    stamp_gt;
        logic    out_free;
    } t_stat;

endpackage

// ===== design/tro_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one request word into the oracle.
// ----------------------------------------------------------------------------
interface tro_req_if import tro_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [2:0]       opcode;
    logic [PC_W-1:0]  branch_pc;
    logic [UPC_W-1:0] micro_pc;
    logic [PC_W-1:0]  target_pc;
    logic [UPC_W-1:0] target_micro_pc;
    logic [SEQ_W-1:0] seq_num;

    modport source (
        output valid, opcode, branch_pc, micro_pc, target_pc, target_micro_pc, seq_num,
        input  ready
    );

    modport sink (
        input  valid, opcode, branch_pc, micro_pc, target_pc, target_micro_pc, seq_num,
        output ready
    );

endinterface

// ===== design/tro_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response word out of the oracle.
// ----------------------------------------------------------------------------
interface tro_rsp_if import tro_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             taken;
    logic [PC_W-1:0]  predicted_pc;
    logic [UPC_W-1:0] predicted_micro_pc;
    logic [1:0]       status;

    modport source (
        output valid, taken, predicted_pc, predicted_micro_pc, status,
        input  ready
    );

    modport sink (
        input  valid, taken, predicted_pc, predicted_micro_pc, status,
        output ready
    );

endinterface

// ===== design/tro_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tro_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tro_datapath.sv =====
// ----------------------------------------------------------------------------
// Trace replay datapath
// Ring pointers and counts, entry and stamp memories, and the response register.
// ----------------------------------------------------------------------------
module tro_datapath import tro_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    input  logic [2:0]       i_opcode,
    input  logic [PC_W-1:0]  i_branch_pc,
    input  logic [UPC_W-1:0] i_micro_pc,
    input  logic [PC_W-1:0]  i_target_pc,
    input  logic [UPC_W-1:0] i_target_micro_pc,
    input  logic [SEQ_W-1:0] i_seq_num,
    tro_rsp_if.source        o_rsp
);

    localparam int unsigned IDX_W = $clog2(ENTRIES);
    localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(ENTRIES - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(ENTRIES - 1) : idx - IDX_W'(1);
    endfunction

    t_opcode          r_op;
    logic [PC_W-1:0]  r_pc;
    logic [UPC_W-1:0] r_upc;
    logic [PC_W-1:0]  r_tpc;
    logic [UPC_W-1:0] r_tupc;
    logic [SEQ_W-1:0] r_seq;

    logic [IDX_W-1:0] r_oldest, n_oldest;
    logic [IDX_W-1:0] r_nu, n_nu;
    logic [IDX_W-1:0] r_append, n_append;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_unused, n_unused;
    logic             r_finished, n_finished;

    logic             r_taken, n_taken;
    logic [PC_W-1:0]  r_ppc, n_ppc;
    logic [UPC_W-1:0] r_pupc, n_pupc;
    t_status          r_status, n_status;

    logic             r_o_valid, n_o_valid;
    logic             r_o_taken;
    logic [PC_W-1:0]  r_o_ppc;
    logic [UPC_W-1:0] r_o_pupc;
    t_status          r_o_status;

    t_entry           entry_wdata;
    logic [ENTRY_W-1:0] entry_rbits;
    t_entry           entry_rdata;
    logic             entry_we;
    logic [SEQ_W-1:0] stamp_rdata;
    logic             stamp_we;
    logic [IDX_W-1:0] stamp_raddr;
    logic [IDX_W-1:0] nu_prev;
    logic [CNT_W:0]   fill;
    logic             full;
    logic             match;
    logic             stamp_gt;

    assign nu_prev     = idx_prev(r_nu);
    assign fill        = {1'b0, r_used} + {1'b0, r_unused};
    assign full        = (fill >= (CNT_W + 1)'(ENTRIES));
    assign entry_rdata = t_entry'(entry_rbits);
    assign match       = (entry_rdata.branch_pc == r_pc) && (entry_rdata.branch_upc == r_upc);
    assign stamp_gt    = (stamp_rdata > r_seq);

    assign entry_wdata = '{branch_pc: r_pc, branch_upc: r_upc,
                           target_pc: r_tpc, target_upc: r_tupc};
    assign entry_we    = i_cmd.exec && (r_op == OP_LOAD) && !full;
    assign stamp_we    = i_cmd.eval && (r_op == OP_PREDICT) && match;
    assign stamp_raddr = (r_op == OP_SQUASH) ? nu_prev : r_oldest;

    tro_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (entry_we),
        .i_waddr (r_append),
        .i_wdata (entry_wdata),
        .i_raddr (r_nu),
        .o_rdata (entry_rbits)
    );

    tro_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (ENTRIES)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (stamp_we),
        .i_waddr (r_nu),
        .i_wdata (r_seq),
        .i_raddr (stamp_raddr),
        .o_rdata (stamp_rdata)
    );

    always_comb begin
        n_oldest   = r_oldest;
        n_nu       = r_nu;
        n_append   = r_append;
        n_used     = r_used;
        n_unused   = r_unused;
        n_finished = r_finished;
        n_taken    = r_taken;
        n_ppc      = r_ppc;
        n_pupc     = r_pupc;
        n_status   = r_status;

        if (i_cmd.capture) begin
            n_taken  = 1'b0;
            n_ppc    = '0;
            n_pupc   = '0;
            n_status = STAT_OK;
        end

        if (i_cmd.exec) begin
            case (r_op)
                OP_LOAD: begin
                    if (full) begin
                        n_status = STAT_FULL;
                    end else begin
                        n_append = idx_next(r_append);
                        n_unused = r_unused + CNT_W'(1);
                    end
                end
                OP_END: begin
                    n_finished = 1'b1;
                end
                OP_PREDICT: begin
                    if (r_unused == '0) begin
                        n_status = r_finished ? STAT_OK : STAT_REFILL;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.eval) begin
            case (r_op)
                OP_PREDICT: begin
                    if (match) begin
                        n_taken  = 1'b1;
                        n_ppc    = entry_rdata.target_pc;
                        n_pupc   = entry_rdata.target_upc;
                        n_nu     = idx_next(r_nu);
                        n_used   = r_used + CNT_W'(1);
                        n_unused = r_unused - CNT_W'(1);
                    end
                end
                OP_SQUASH: begin
                    if (stamp_gt) begin
                        n_nu     = nu_prev;
                        n_used   = r_used - CNT_W'(1);
                        n_unused = r_unused + CNT_W'(1);
                    end
                end
                OP_COMMIT: begin
                    if (!stamp_gt) begin
                        n_oldest = idx_next(r_oldest);
                        n_used   = r_used - CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (i_cmd.emit) begin
            n_o_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest   <= '0;
            r_nu       <= '0;
            r_append   <= '0;
            r_used     <= '0;
            r_unused   <= '0;
            r_finished <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_oldest   <= n_oldest;
            r_nu       <= n_nu;
            r_append   <= n_append;
            r_used     <= n_used;
            r_unused   <= n_unused;
            r_finished <= n_finished;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_opcode'(i_opcode);
            r_pc   <= i_branch_pc;
            r_upc  <= i_micro_pc;
            r_tpc  <= i_target_pc;
            r_tupc <= i_target_micro_pc;
            r_seq  <= i_seq_num;
        end
        r_taken  <= n_taken;
        r_ppc    <= n_ppc;
        r_pupc   <= n_pupc;
        r_status <= n_status;
        if (i_cmd.emit) begin
            r_o_taken  <= r_taken;
            r_o_ppc    <= r_ppc;
            r_o_pupc   <= r_pupc;
            r_o_status <= r_status;
        end
    end

    assign o_stat = '{op: r_op, used_zero: (r_used == '0), unused_zero: (r_unused == '0),
                      stamp_gt: stamp_gt, out_free: (!r_o_valid || o_rsp.ready)};

    assign o_rsp.valid              = r_o_valid;
    assign o_rsp.taken              = r_o_taken;
    assign o_rsp.predicted_pc       = r_o_ppc;
    assign o_rsp.predicted_micro_pc = r_o_pupc;
    assign o_rsp.status             = r_o_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill <= (CNT_W + 1)'(ENTRIES))
        else $error("Ring holds more entries than it has.");

    a_full_load_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && r_op == OP_LOAD && full) |=>
            (r_append == $past(r_append) && r_unused == $past(r_unused)))
        else $error("A dropped load changed the ring.");

    a_commit_keeps_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.eval && r_op == OP_COMMIT) |=> (r_unused == $past(r_unused)))
        else $error("A commit changed the unused count.");

    a_taken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_taken) |-> (r_o_status == STAT_OK))
        else $error("A taken prediction carries a nonzero status.");

endmodule

// ===== design/tro_ctrl.sv =====
// ----------------------------------------------------------------------------
// Trace replay controller
// Sequences capture, execute, memory evaluate and emit for each request.
// ----------------------------------------------------------------------------
module tro_ctrl import tro_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.op)
                    OP_PREDICT: n_state = i_stat.unused_zero ? S_EMIT : S_EVAL;
                    OP_SQUASH:  n_state = i_stat.used_zero ? S_EMIT : S_EVAL;
                    OP_COMMIT:  n_state = i_stat.used_zero ? S_EMIT : S_EVAL;
                    default:    n_state = S_EMIT;
                endcase
            end
            S_EVAL: begin
                case (i_stat.op)
                    OP_SQUASH: n_state = i_stat.stamp_gt ? S_EXEC : S_EMIT;
                    OP_COMMIT: n_state = i_stat.stamp_gt ? S_EMIT : S_EXEC;
                    default:   n_state = S_EMIT;
                endcase
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready   = (r_state == S_IDLE);
        o_cmd.capture = (r_state == S_IDLE) && i_req_valid;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.eval    = (r_state == S_EVAL);
        o_cmd.emit    = (r_state == S_EMIT) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_EXEC))
        else $error("An accepted word did not start execution.");

    a_eval_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_EXEC))
        else $error("Memory evaluate entered without a read issued.");

    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !i_stat.out_free) |=> (r_state == S_EMIT))
        else $error("A response was lost while the output was busy.");

endmodule

// ===== design/trace_replay_branch_oracle.sv =====
// ----------------------------------------------------------------------------
// Trace replay branch oracle
// Replays a ring of recorded taken branches as an oracle branch predictor.
// ----------------------------------------------------------------------------
// The request channel carries one word per operation: load an entry, end of
// trace, predict, squash or commit. Every request word produces exactly one
// response word on the response channel, in order.
// For load, end of trace, unassigned operations and a predict that finds no
// unused entry, the controller goes from execute straight to emit. A predict
// that reads the entry memory passes through memory evaluate between them,
// because that read is registered.
// Squash and commit pass through execute and memory evaluate for every entry
// they release, and once more when a stamp ends the walk, since each step
// reads one stamp from the stamp memory's single read port.
// One request is in flight at a time; the next word is accepted the cycle
// after the response has been moved into the output register.
// While the receiver stalls, the response word is held in the output
// register and a following request is still accepted and worked on; it
// waits before its own response until the output register frees up.
// Reset empties the ring and clears the end of trace flag. Memory contents
// are not cleared, since no entry is read before it is written.
// ----------------------------------------------------------------------------
module trace_replay_branch_oracle import tro_pkg::*; #(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tro_req_if.sink   i_req,
    tro_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    tro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tro_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_opcode          (i_req.opcode),
        .i_branch_pc       (i_req.branch_pc),
        .i_micro_pc        (i_req.micro_pc),
        .i_target_pc       (i_req.target_pc),
        .i_target_micro_pc (i_req.target_micro_pc),
        .i_seq_num         (i_req.seq_num),
        .o_rsp             (o_rsp)
    );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace replay branch oracle testbench
// Drives load, end of trace, predict, squash and commit words through the
// request channel while both channels idle and stall at random. Each response
// word is compared with a replay of the recorded-branch ring kept in the
// bench, or with a value typed into the directed rows.
// ----------------------------------------------------------------------------
module testbench;
    import tro_pkg::*;

    localparam int unsigned SLOTS        = ENTRIES_DEF;
    localparam int          HALF_PERIOD  = 10;
    localparam longint      TIMEOUT_NS   = 64'd24_000_000;
    localparam int unsigned N_ROWS       = 29;
    localparam int unsigned N_OPEN       = 26;
    localparam int unsigned RANDOM_FIRST = 1300;
    localparam int unsigned RANDOM_LAST  = 220;
    localparam int unsigned LONG_HOLD_AT = 500;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 140;
    localparam int unsigned QUIET_SPAN   = 80;
    localparam int unsigned DUE_DEPTH    = 16;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam logic [PC_W-1:0]  ONES     = '1;
    localparam logic [UPC_W-1:0] UPC_ONES = '1;
    localparam logic [PC_W-1:0]  PC_A     = 64'h0123_4567_89AB_CDEF;

    typedef enum {MIX_FILL, MIX_REPLAY, MIX_BLEND} t_mix;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [PC_W-1:0]  branch_pc;
        logic [UPC_W-1:0] micro_pc;
        logic [PC_W-1:0]  target_pc;
        logic [UPC_W-1:0] target_micro_pc;
        logic [SEQ_W-1:0] seq_num;
    } t_word;

    typedef struct packed {
        logic             taken;
        logic [PC_W-1:0]  predicted_pc;
        logic [UPC_W-1:0] predicted_micro_pc;
        logic [1:0]       status;
    } t_answer;

    typedef struct packed {
        t_word   word;
        logic    typed;
        t_answer answer;
    } t_row;

    localparam t_answer NO_BRANCH = '{1'b0, 64'd0, 16'd0, STAT_OK};

    logic i_clk = 1'b0;
    logic i_rst_n;

    tro_req_if req_ch ();
    tro_rsp_if rsp_ch ();

    trace_replay_branch_oracle #(
        .ENTRIES (SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    logic [PC_W-1:0]  rec_branch_pc  [SLOTS];
    logic [UPC_W-1:0] rec_branch_upc [SLOTS];
    logic [PC_W-1:0]  rec_target_pc  [SLOTS];
    logic [UPC_W-1:0] rec_target_upc [SLOTS];
    logic [SEQ_W-1:0] rec_stamp      [SLOTS];
    int unsigned      oldest_slot = 0;
    int unsigned      next_slot   = 0;
    int unsigned      append_slot = 0;
    int unsigned      n_used      = 0;
    int unsigned      n_unused    = 0;
    bit               trace_done  = 1'b0;

    t_answer          answers_due [DUE_DEPTH];
    int unsigned      due_rd    = 0;
    int unsigned      due_wr    = 0;
    int unsigned      due_count = 0;
    logic [SEQ_W-1:0] seq_clock;
    int unsigned      n_sent    = 0;
    int unsigned      n_answers = 0;
    int unsigned      n_errors  = 0;
    bit               send_quiet = 1'b0;
    bit               take_quiet = 1'b0;

    t_row stim_rows [N_ROWS] = '{
        '{'{OP_PREDICT, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1,
          '{1'b0, 64'd0, 16'd0, STAT_REFILL}},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_COMMIT, 64'd0, 16'd0, 64'd0, 16'd0, ONES}, 1'b1, NO_BRANCH},
        '{'{OP_LOAD, 64'd0, 16'd0, ONES, UPC_ONES, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_LOAD, ONES, UPC_ONES, 64'd0, 16'd0, ONES}, 1'b1, NO_BRANCH},
        '{'{OP_PREDICT, 64'd0, 16'd1, 64'd0, 16'd0, 64'd3}, 1'b1, NO_BRANCH},
        '{'{OP_PREDICT, 64'd0, 16'd0, 64'd0, 16'd0, 64'd5}, 1'b1,
          '{1'b1, ONES, UPC_ONES, STAT_OK}},
        '{'{OP_PREDICT, ONES, UPC_ONES, 64'd0, 16'd0, ONES}, 1'b1,
          '{1'b1, 64'd0, 16'd0, STAT_OK}},
        '{'{OP_PREDICT, ONES, UPC_ONES, 64'd0, 16'd0, 64'd9}, 1'b1,
          '{1'b0, 64'd0, 16'd0, STAT_REFILL}},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, 64'd5}, 1'b1, NO_BRANCH},
        '{'{OP_PREDICT, ONES, UPC_ONES, 64'd0, 16'd0, 64'd7}, 1'b1,
          '{1'b1, 64'd0, 16'd0, STAT_OK}},
        '{'{OP_COMMIT, 64'd0, 16'd0, 64'd0, 16'd0, 64'd6}, 1'b1, NO_BRANCH},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, 64'd7}, 1'b1, NO_BRANCH},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, 64'd6}, 1'b1, NO_BRANCH},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_COMMIT, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_SPARE_LO, PC_A, 16'h5A5A, 64'hA5A5_5A5A_A5A5_5A5A, 16'hA5A5,
            64'h0F0F_F0F0_0F0F_F0F0}, 1'b1, NO_BRANCH},
        '{'{OP_SPARE_MID, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_SPARE_HI, ONES, UPC_ONES, ONES, UPC_ONES, ONES}, 1'b1, NO_BRANCH},
        '{'{OP_LOAD, PC_A, 16'h1234, 64'hFEDC_BA98_7654_3210, 16'h4321, 64'd0}, 1'b1,
          NO_BRANCH},
        '{'{OP_PREDICT, ONES, UPC_ONES, 64'd0, 16'd0, 64'd0}, 1'b0, NO_BRANCH},
        '{'{OP_COMMIT, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b0, NO_BRANCH},
        '{'{OP_PREDICT, PC_A, 16'h1235, 64'd0, 16'd0, 64'd11}, 1'b0, NO_BRANCH},
        '{'{OP_PREDICT, PC_A ^ 64'd1, 16'h1234, 64'd0, 16'd0, 64'd12}, 1'b0, NO_BRANCH},
        '{'{OP_PREDICT, PC_A, 16'h1234, 64'd0, 16'd0, ONES}, 1'b0, NO_BRANCH},
        '{'{OP_SQUASH, 64'd0, 16'd0, 64'd0, 16'd0, ONES - 64'd1}, 1'b0, NO_BRANCH},
        '{'{OP_END, 64'd0, 16'd0, 64'd0, 16'd0, 64'd0}, 1'b1, NO_BRANCH},
        '{'{OP_END, ONES, UPC_ONES, ONES, UPC_ONES, ONES}, 1'b1, NO_BRANCH},
        '{'{OP_LOAD, 64'h8000_0000_0000_0001, 16'h8001, 64'h7FFF_FFFF_FFFF_FFFE,
            16'h7FFE, 64'd0}, 1'b0, NO_BRANCH}
    };

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned idle_cycles(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    // Replays one word against the bench's copy of the ring.
    function automatic t_answer oracle_answer(input t_word w);
        t_answer a;
        a = NO_BRANCH;
        case (w.opcode)
            OP_LOAD: begin
                if (n_used + n_unused >= SLOTS) begin
                    a.status = STAT_FULL;
                end else begin
                    rec_branch_pc[append_slot]  = w.branch_pc;
                    rec_branch_upc[append_slot] = w.micro_pc;
                    rec_target_pc[append_slot]  = w.target_pc;
                    rec_target_upc[append_slot] = w.target_micro_pc;
                    rec_stamp[append_slot]      = '0;
                    append_slot = (append_slot + 1) % SLOTS;
                    n_unused++;
                end
            end
            OP_END: trace_done = 1'b1;
            OP_PREDICT: begin
                if (n_unused == 0) begin
                    a.status = trace_done ? STAT_OK : STAT_REFILL;
                end else if (rec_branch_pc[next_slot] == w.branch_pc &&
                             rec_branch_upc[next_slot] == w.micro_pc) begin
                    rec_stamp[next_slot] = w.seq_num;
                    a.taken              = 1'b1;
                    a.predicted_pc       = rec_target_pc[next_slot];
                    a.predicted_micro_pc = rec_target_upc[next_slot];
                    next_slot = (next_slot + 1) % SLOTS;
                    n_used++;
                    n_unused--;
                end
            end
            OP_SQUASH: begin
                while (n_used > 0 && rec_stamp[(next_slot + SLOTS - 1) % SLOTS] > w.seq_num) begin
                    next_slot = (next_slot + SLOTS - 1) % SLOTS;
                    rec_stamp[next_slot] = '0;
                    n_used--;
                    n_unused++;
                end
            end
            OP_COMMIT: begin
                while (n_used > 0 && rec_stamp[oldest_slot] <= w.seq_num) begin
                    oldest_slot = (oldest_slot + 1) % SLOTS;
                    n_used--;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic send_word(input t_word w, input logic typed, input t_answer typed_answer);
        t_answer     predicted;
        int unsigned gap;
        if (n_sent % QUIET_SPAN == 0) send_quiet = ($urandom_range(0, 3) == 0);
        gap = idle_cycles(send_quiet);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.opcode          <= w.opcode;
        req_ch.branch_pc       <= w.branch_pc;
        req_ch.micro_pc        <= w.micro_pc;
        req_ch.target_pc       <= w.target_pc;
        req_ch.target_micro_pc <= w.target_micro_pc;
        req_ch.seq_num         <= w.seq_num;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predicted = oracle_answer(w);
        answers_due[due_wr] = typed ? typed_answer : predicted;
        due_wr = (due_wr + 1) % DUE_DEPTH;
        due_count++;
        n_sent++;
    endtask

    // Most words follow the recorded trace so that predicts hit and the ring
    // both fills up and drains; a few are pure noise.
    task automatic send_random(input int unsigned count, input bit end_allowed);
        t_word       w;
        t_mix        mix;
        int unsigned pick;
        int unsigned slot;
        mix = MIX_BLEND;
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 96 == 0) mix = t_mix'($urandom_range(0, 2));
            w = '0;
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w.opcode = 3'($urandom_range(0, 7));
                if (w.opcode == OP_END && !end_allowed) w.opcode = OP_PREDICT;
                w.branch_pc       = rand64();
                w.micro_pc        = 16'($urandom);
                w.target_pc       = rand64();
                w.target_micro_pc = 16'($urandom);
                w.seq_num         = rand64();
            end else if (end_allowed && pick < 10) begin
                w.opcode = OP_END;
            end else begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL: w.opcode = (pick < 60) ? OP_LOAD : (pick < 85) ? OP_PREDICT :
                                         (pick < 90) ? OP_SQUASH : OP_COMMIT;
                    MIX_REPLAY: w.opcode = (pick < 15) ? OP_LOAD : (pick < 70) ? OP_PREDICT :
                                           (pick < 80) ? OP_SQUASH : OP_COMMIT;
                    default: w.opcode = (pick < 30) ? OP_LOAD : (pick < 70) ? OP_PREDICT :
                                        (pick < 82) ? OP_SQUASH : OP_COMMIT;
                endcase
                case (w.opcode)
                    OP_LOAD: begin
                        w.branch_pc = ($urandom_range(0, 3) == 0) ?
                                      64'($urandom_range(0, 15)) : rand64();
                        w.micro_pc  = ($urandom_range(0, 3) == 0) ?
                                      16'($urandom_range(0, 3)) : 16'($urandom);
                        w.target_pc       = rand64();
                        w.target_micro_pc = 16'($urandom);
                    end
                    OP_PREDICT: begin
                        seq_clock += 64'($urandom_range(1, 4));
                        w.seq_num = seq_clock;
                        if (n_unused != 0) begin
                            w.branch_pc = rec_branch_pc[next_slot];
                            w.micro_pc  = rec_branch_upc[next_slot];
                        end
                        case ($urandom_range(0, 7))
                            0: w.branch_pc ^= rand64() | 64'd1;
                            1: w.micro_pc  ^= 16'($urandom_range(1, 65535));
                            2: begin
                                w.branch_pc = rand64();
                                w.micro_pc  = 16'($urandom);
                            end
                            default: ;
                        endcase
                    end
                    default: begin
                        if (n_used != 0 && $urandom_range(0, 4) != 0) begin
                            slot = (oldest_slot + $urandom_range(0, n_used - 1)) % SLOTS;
                            w.seq_num = rec_stamp[slot] - 64'($urandom_range(0, 1));
                        end else begin
                            case ($urandom_range(0, 2))
                                0: w.seq_num = '0;
                                1: w.seq_num = '1;
                                default: w.seq_num = rand64();
                            endcase
                        end
                    end
                endcase
            end
            send_word(w, 1'b0, NO_BRANCH);
        end
    endtask

    task automatic check_answer(input t_answer got);
        t_answer want;
        if (due_count == 0) begin
            $error("response word with none outstanding: taken %0b, pc %h, status %0d",
                   got.taken, got.predicted_pc, got.status);
            n_errors++;
            return;
        end
        want = answers_due[due_rd];
        due_rd = (due_rd + 1) % DUE_DEPTH;
        due_count--;
        if (got.taken !== want.taken) begin
            $error("taken: expected %0b, got %0b", want.taken, got.taken);
            n_errors++;
        end
        if (got.predicted_pc !== want.predicted_pc) begin
            $error("predicted_pc: expected %h, got %h", want.predicted_pc, got.predicted_pc);
            n_errors++;
        end
        if (got.predicted_micro_pc !== want.predicted_micro_pc) begin
            $error("predicted_micro_pc: expected %h, got %h",
                   want.predicted_micro_pc, got.predicted_micro_pc);
            n_errors++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
        end
    endtask

    // Response side; one long hold-off lets the oracle back up into its input.
    initial begin
        int unsigned hold;
        hold = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
                check_answer('{rsp_ch.taken, rsp_ch.predicted_pc,
                               rsp_ch.predicted_micro_pc, rsp_ch.status});
                n_answers++;
                if (n_answers % QUIET_SPAN == 0) take_quiet = ($urandom_range(0, 3) == 0);
                hold = (n_answers == LONG_HOLD_AT) ? LONG_HOLD : idle_cycles(take_quiet);
            end
            if (hold > 0) begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n                <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.opcode          <= OP_LOAD;
        req_ch.branch_pc       <= '0;
        req_ch.micro_pc        <= '0;
        req_ch.target_pc       <= '0;
        req_ch.target_micro_pc <= '0;
        req_ch.seq_num         <= '0;
        seq_clock = rand64() >> 2;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int unsigned r = 0; r < N_ROWS; r++) begin
            if (r == N_OPEN) begin
                send_random(RANDOM_FIRST, 1'b0);
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (due_count != 0);
            end
            send_word(stim_rows[r].word, stim_rows[r].typed, stim_rows[r].answer);
        end
        send_random(RANDOM_LAST, 1'b1);
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (due_count != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tro_pkg.sv
design/tro_req_if.sv
design/tro_rsp_if.sv
design/tro_ram.sv
design/tro_datapath.sv
design/tro_ctrl.sv
design/trace_replay_branch_oracle.sv
verif/testbench.sv
